// ===== rtl/core/code128_set_c_encoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Code 128 set C encoder: assertion macros
// Shared concurrent assertion forms, used by c128c_emit.
// ----------------------------------------------------------------------------
`ifndef CODE128_SET_C_ENCODER_UNIT_DEFINES_SVH
`define CODE128_SET_C_ENCODER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define C128C_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("c128c: invariant violated");

// A consequence that must hold in the same cycle as its antecedent.
`define C128C_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c128c: implication violated");

`endif

// ===== rtl/core/c128c_pkg.sv =====
// ----------------------------------------------------------------------------
// c128c_pkg
// Constants, types and the symbol pattern table of the Code 128 set C encoder.
// ----------------------------------------------------------------------------
package c128c_pkg;

  // Message length in symbol values.
  localparam int NUM_PAIRS = 8;
  localparam logic [6:0] NUM_PAIRS_W = 7'(NUM_PAIRS);

  // Special symbols and checksum modulus.
  localparam logic [6:0] SYM_START_C = 7'd105;
  localparam logic [6:0] SYM_STOP    = 7'd106;
  localparam int         CHECK_MOD   = 103;
  localparam logic [6:0] CHECK_MOD_W = 7'(CHECK_MOD);
  localparam logic [7:0] CHECK_MOD_X2 = 8'(2 * CHECK_MOD);
  localparam logic [6:0] CSUM_INIT   = 7'(105 % CHECK_MOD);

  // Pattern module counts.
  localparam logic [3:0] PAT_WIDTH_STD  = 4'd11;
  localparam logic [3:0] PAT_WIDTH_STOP = 4'd13;

  // Kind of an emitted symbol.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_CHECK = 2'd2,
    KIND_STOP  = 2'd3
  } kind_t;

  // One accepted item with its weighted product, between the two stages.
  typedef struct packed {
    logic [6:0]  value;
    logic [13:0] prod;
    logic        first;
    logic        last;
  } s1_item_t;

  // The symbol currently offered on the result channel.
  typedef struct packed {
    kind_t      kind;
    logic [6:0] index;
    logic       bad;
  } slot_t;

  // Residue of (hi * 128) modulo the checksum modulus, for a 7-bit hi.
  typedef logic [6:0] hi_mod_tbl_t [128];

  localparam int HI_STEP = 128 % CHECK_MOD;

  function automatic hi_mod_tbl_t build_hi_mod();
    hi_mod_tbl_t tbl;
    int          acc;
    acc = 0;
    for (int i = 0; i < 128; i++) begin
      tbl[i] = 7'(acc);
      acc = acc + HI_STEP;
      if (acc >= CHECK_MOD) begin
        acc = acc - CHECK_MOD;
      end
    end
    return tbl;
  endfunction

  localparam hi_mod_tbl_t HI_MOD_TBL = build_hi_mod();

  // Code 128 bar/space patterns, MSB first, 1 = bar.
  localparam logic [12:0] PAT_TABLE [107] = '{
    13'h6cc, 13'h66c, 13'h666, 13'h498, 13'h48c, 13'h44c, 13'h4c8, 13'h4c4,
    13'h464, 13'h648, 13'h644, 13'h624, 13'h59c, 13'h4dc, 13'h4ce, 13'h5cc,
    13'h4ec, 13'h4e6, 13'h672, 13'h65c, 13'h64e, 13'h6e4, 13'h674, 13'h76e,
    13'h74c, 13'h72c, 13'h726, 13'h764, 13'h734, 13'h732, 13'h6d8, 13'h6c6,
    13'h636, 13'h518, 13'h458, 13'h446, 13'h588, 13'h468, 13'h462, 13'h688,
    13'h628, 13'h622, 13'h5b8, 13'h58e, 13'h46e, 13'h5d8, 13'h5c6, 13'h476,
    13'h776, 13'h68e, 13'h62e, 13'h6e8, 13'h6e2, 13'h6ee, 13'h758, 13'h746,
    13'h716, 13'h768, 13'h762, 13'h71a, 13'h77a, 13'h642, 13'h78a, 13'h530,
    13'h50c, 13'h4b0, 13'h486, 13'h42c, 13'h426, 13'h590, 13'h584, 13'h4d0,
    13'h4c2, 13'h434, 13'h432, 13'h612, 13'h650, 13'h7ba, 13'h614, 13'h47a,
    13'h53c, 13'h4bc, 13'h49e, 13'h5e4, 13'h4f4, 13'h4f2, 13'h7a4, 13'h794,
    13'h792, 13'h6de, 13'h6f6, 13'h7b6, 13'h578, 13'h51e, 13'h45e, 13'h5e8,
    13'h5e2, 13'h7a8, 13'h7a2, 13'h5de, 13'h5ee, 13'h75e, 13'h7ae, 13'h684,
    13'h690, 13'h69c, 13'h18eb
  };

  // Pattern of a symbol; values beyond the table give an all-space pattern.
  function automatic logic [12:0] pat_lookup(input logic [6:0] idx);
    logic [12:0] pat;
    if (idx <= SYM_STOP) begin
      pat = PAT_TABLE[idx];
    end else begin
      pat = 13'h0;
    end
    return pat;
  endfunction

endpackage

// ===== rtl/core/c128c_in_stage.sv =====
// ----------------------------------------------------------------------------
// c128c_in_stage
// Input register: tracks the position in the message and forms the weighted
// product of position and symbol value for the checksum.
// ----------------------------------------------------------------------------
module c128c_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [6:0]           in_symbol_value,
  output logic                 s1_valid,
  output c128c_pkg::s1_item_t  s1_item,
  input  logic                 s1_take
);
  import c128c_pkg::*;

  logic       s1_valid_r;
  s1_item_t   item_r;
  logic [6:0] pos_r;
  logic [6:0] pos_inc;
  logic       in_xfer;
  logic       is_last;
  logic [13:0] prod;

  // The register frees up whenever its item moves on in the same cycle.
  assign in_ready = !s1_valid_r || s1_take;
  assign in_xfer  = in_valid && in_ready;

  // Position weights count from one; the message ends at NUM_PAIRS items.
  assign pos_inc = pos_r + 7'd1;
  assign is_last = (pos_inc >= NUM_PAIRS_W);
  assign prod    = 14'(pos_inc) * 14'(in_symbol_value);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= 7'd0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
        pos_r      <= is_last ? 7'd0 : pos_inc;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Item payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.value <= in_symbol_value;
      item_r.prod  <= prod;
      item_r.first <= (pos_r == 7'd0);
      item_r.last  <= is_last;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = item_r;

endmodule

// ===== rtl/core/c128c_emit.sv =====
// ----------------------------------------------------------------------------
// c128c_emit
// Result register: folds the product into the running checksum and holds the
// group of symbols one item causes, handing them out one per transfer.
// ----------------------------------------------------------------------------
`include "code128_set_c_encoder_unit_defines.svh"

module c128c_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  c128c_pkg::s1_item_t  s1_item,
  output logic                 s1_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output c128c_pkg::slot_t     slot
);
  import c128c_pkg::*;

  // Pending symbols: bit 0 start, 1 data, 2 check, 3 stop.
  logic [3:0] mask_r;
  logic [6:0] value_r;
  logic [6:0] check_r;
  logic [6:0] cs_r;

  logic [3:0] sel;
  logic [3:0] mask_clr;
  logic       group_valid;
  logic       out_xfer;
  logic       finishing;
  logic [6:0] hi_res;
  logic [7:0] lo_sum;
  logic [6:0] prod_mod;
  logic [6:0] cs_base;
  logic [7:0] cs_sum;
  logic [6:0] cs_new;

  assign group_valid = |mask_r;
  assign out_valid   = group_valid;
  assign out_xfer    = group_valid && out_ready;

  // Oldest pending symbol goes first.
  always_comb begin
    sel        = 4'b0000;
    slot.kind  = KIND_STOP;
    slot.index = SYM_STOP;
    slot.bad   = 1'b0;
    if (mask_r[0]) begin
      sel        = 4'b0001;
      slot.kind  = KIND_START;
      slot.index = SYM_START_C;
    end else if (mask_r[1]) begin
      sel        = 4'b0010;
      slot.kind  = KIND_DATA;
      slot.index = value_r;
      slot.bad   = (value_r > SYM_STOP);
    end else if (mask_r[2]) begin
      sel        = 4'b0100;
      slot.kind  = KIND_CHECK;
      slot.index = check_r;
    end else if (mask_r[3]) begin
      sel        = 4'b1000;
    end
  end

  assign mask_clr  = mask_r & ~sel;
  assign finishing = out_xfer && (mask_clr == 4'b0000);
  assign s1_take   = s1_valid && (!group_valid || finishing);

  // Product modulo 103: table for the high half, then a conditional subtract of 206 or 103.
  assign hi_res = HI_MOD_TBL[s1_item.prod[13:7]];
  assign lo_sum = 8'(hi_res) + 8'(s1_item.prod[6:0]);

  always_comb begin
    if (lo_sum >= CHECK_MOD_X2) begin
      prod_mod = 7'(lo_sum - CHECK_MOD_X2);
    end else if (lo_sum >= 8'(CHECK_MOD_W)) begin
      prod_mod = 7'(lo_sum - 8'(CHECK_MOD_W));
    end else begin
      prod_mod = lo_sum[6:0];
    end
  end

  // Accumulate; a new message restarts from the start symbol's weight.
  assign cs_base = s1_item.first ? CSUM_INIT : cs_r;
  assign cs_sum  = 8'(cs_base) + 8'(prod_mod);
  assign cs_new  = (cs_sum >= 8'(CHECK_MOD_W)) ? 7'(cs_sum - 8'(CHECK_MOD_W))
                                               : cs_sum[6:0];

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 4'b0000;
      cs_r   <= CSUM_INIT;
    end else begin
      if (s1_take) begin
        mask_r <= {s1_item.last, s1_item.last, 1'b1, s1_item.first};
        cs_r   <= s1_item.last ? CSUM_INIT : cs_new;
      end else if (out_xfer) begin
        mask_r <= mask_clr;
      end
    end
  end

  // Group payload.
  always_ff @(posedge clk) begin
    if (s1_take) begin
      value_r <= s1_item.value;
      check_r <= cs_new;
    end
  end

  `C128C_ASSERT_ALWAYS(a_csum_range, cs_r < CHECK_MOD_W)
  `C128C_ASSERT_IMPLIES(a_check_before_stop, mask_r[2], mask_r[3])
  `C128C_ASSERT_IMPLIES(a_check_index, mask_r[2], check_r < CHECK_MOD_W)

endmodule

// ===== rtl/core/code128_set_c_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// code128_set_c_encoder_unit
// Code 128 set C encoder: symbol values in, bar/space patterns out.
// ----------------------------------------------------------------------------
// A message is c128c_pkg::NUM_PAIRS symbol values, one per input transfer.
// The first value of a message is preceded by the start C pattern, and the
// last is followed by the modulo-103 check symbol and the 13-module stop
// pattern. Each value yields one to three result transfers (two for the first
// value, three for the last), and the result port, which carries one symbol
// per cycle while out_ready is high, sets the rate: an input transfer can be
// taken every cycle for values in the middle of a message. The first result
// of a value is offered from the result register once the value has passed
// the input register. Values above 106 give an all-space pattern with
// out_bad_value set, and still enter the checksum.
// ----------------------------------------------------------------------------
module code128_set_c_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  in_symbol_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] out_pattern,
  output logic [3:0]  out_pattern_width,
  output logic [1:0]  out_symbol_kind,
  output logic        out_last_of_message,
  output logic        out_bad_value
);
  import c128c_pkg::*;

  logic     s1_valid;
  logic     s1_take;
  s1_item_t s1_item;
  slot_t    slot;

  // Position tracking and weighted product.
  c128c_in_stage u_in_stage (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_symbol_value (in_symbol_value),
    .s1_valid        (s1_valid),
    .s1_item         (s1_item),
    .s1_take         (s1_take)
  );

  // Checksum and symbol group sequencing.
  c128c_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot      (slot)
  );

  // Pattern lookup and result fields for the symbol on offer.
  assign out_pattern         = pat_lookup(slot.index);
  assign out_pattern_width   = (slot.kind == KIND_STOP) ? PAT_WIDTH_STOP : PAT_WIDTH_STD;
  assign out_symbol_kind     = slot.kind;
  assign out_last_of_message = (slot.kind == KIND_STOP);
  assign out_bad_value       = slot.bad;

endmodule

// ===== test/code128_set_c_encoder_checker.sv =====
// ----------------------------------------------------------------------------
// code128_set_c_encoder_checker
// Watches both channels of the set C encoder, predicts the symbol stream from
// every accepted value and compares each result transfer with the prediction.
// ----------------------------------------------------------------------------
module code128_set_c_encoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [6:0]  in_symbol_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [12:0] out_pattern,
  input  logic [3:0]  out_pattern_width,
  input  logic [1:0]  out_symbol_kind,
  input  logic        out_last_of_message,
  input  logic        out_bad_value,
  output int          fail_count,
  output int          pending_count,
  output int          message_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import c128c_pkg::*;

  // Symbol codes and checksum rules of Code 128 set C.
  localparam logic [6:0] START_C_CODE = 7'd105;
  localparam logic [6:0] STOP_CODE    = 7'd106;
  localparam int         SUM_MODULUS  = 103;
  localparam logic [6:0] SUM_SEED     = 7'(105 % SUM_MODULUS);
  localparam logic [3:0] MODULES_STD  = 4'd11;
  localparam logic [3:0] MODULES_STOP = 4'd13;

  // Published bar/space patterns, MSB first, one bit per module.
  localparam logic [12:0] BAR_PATTERNS [107] = '{
    13'h6cc, 13'h66c, 13'h666, 13'h498, 13'h48c, 13'h44c, 13'h4c8, 13'h4c4,
    13'h464, 13'h648, 13'h644, 13'h624, 13'h59c, 13'h4dc, 13'h4ce, 13'h5cc,
    13'h4ec, 13'h4e6, 13'h672, 13'h65c, 13'h64e, 13'h6e4, 13'h674, 13'h76e,
    13'h74c, 13'h72c, 13'h726, 13'h764, 13'h734, 13'h732, 13'h6d8, 13'h6c6,
    13'h636, 13'h518, 13'h458, 13'h446, 13'h588, 13'h468, 13'h462, 13'h688,
    13'h628, 13'h622, 13'h5b8, 13'h58e, 13'h46e, 13'h5d8, 13'h5c6, 13'h476,
    13'h776, 13'h68e, 13'h62e, 13'h6e8, 13'h6e2, 13'h6ee, 13'h758, 13'h746,
    13'h716, 13'h768, 13'h762, 13'h71a, 13'h77a, 13'h642, 13'h78a, 13'h530,
    13'h50c, 13'h4b0, 13'h486, 13'h42c, 13'h426, 13'h590, 13'h584, 13'h4d0,
    13'h4c2, 13'h434, 13'h432, 13'h612, 13'h650, 13'h7ba, 13'h614, 13'h47a,
    13'h53c, 13'h4bc, 13'h49e, 13'h5e4, 13'h4f4, 13'h4f2, 13'h7a4, 13'h794,
    13'h792, 13'h6de, 13'h6f6, 13'h7b6, 13'h578, 13'h51e, 13'h45e, 13'h5e8,
    13'h5e2, 13'h7a8, 13'h7a2, 13'h5de, 13'h5ee, 13'h75e, 13'h7ae, 13'h684,
    13'h690, 13'h69c, 13'h18eb
  };

  // One predicted symbol on the result channel.
  typedef struct packed {
    logic [12:0] pattern;
    logic [3:0]  width;
    kind_t       kind;
    logic        last;
    logic        bad;
  } symbol_rec_t;

  symbol_rec_t expected_symbols[$];
  logic [6:0]  msg_pos;
  logic [6:0]  running_sum;

  assign pending_count = expected_symbols.size();

  // Queues one predicted symbol.
  task automatic push_symbol(input logic [12:0] pat, input logic [3:0] width,
                             input kind_t kind, input logic last, input logic bad);
    symbol_rec_t rec;
    rec.pattern = pat;
    rec.width   = width;
    rec.kind    = kind;
    rec.last    = last;
    rec.bad     = bad;
    expected_symbols.push_back(rec);
  endtask

  // Predicts every symbol caused by one accepted value and advances the
  // message position and weighted checksum.
  task automatic encode_symbol(input logic [6:0] value);
    int sum;
    if (msg_pos == 7'd0) begin
      running_sum = SUM_SEED;
      push_symbol(BAR_PATTERNS[START_C_CODE], MODULES_STD, KIND_START, 1'b0, 1'b0);
    end
    // Values past the table give an all-space pattern but still count.
    if (value <= STOP_CODE) begin
      push_symbol(BAR_PATTERNS[value], MODULES_STD, KIND_DATA, 1'b0, 1'b0);
    end else begin
      push_symbol(13'h0, MODULES_STD, KIND_DATA, 1'b0, 1'b1);
    end
    sum = (int'(running_sum) + (int'(msg_pos) + 1) * int'(value)) % SUM_MODULUS;
    running_sum = 7'(sum);
    msg_pos = msg_pos + 7'd1;
    if (int'(msg_pos) >= NUM_PAIRS) begin
      push_symbol(BAR_PATTERNS[running_sum], MODULES_STD, KIND_CHECK, 1'b0, 1'b0);
      push_symbol(BAR_PATTERNS[STOP_CODE], MODULES_STOP, KIND_STOP, 1'b1, 1'b0);
      msg_pos = 7'd0;
      running_sum = SUM_SEED;
    end
  endtask

  // Compares one field of a result transfer.
  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Both channels are sampled at the rising edge.
  always @(posedge clk) begin
    symbol_rec_t rec;
    if (!rst_n) begin
      msg_pos = 7'd0;
      running_sum = SUM_SEED;
      expected_symbols.delete();
    end else begin
      if (in_valid && in_ready) begin
        encode_symbol(in_symbol_value);
      end
      if (out_valid && out_ready) begin
        if (expected_symbols.size() == 0) begin
          $error("result transfer with no expected symbol: pattern 0x%0h kind %0d",
                 out_pattern, out_symbol_kind);
          fail_count++;
        end else begin
          rec = expected_symbols.pop_front();
          check_field("pattern", 16'(rec.pattern), 16'(out_pattern));
          check_field("pattern_width", 16'(rec.width), 16'(out_pattern_width));
          check_field("symbol_kind", 16'(rec.kind), 16'(out_symbol_kind));
          check_field("last_of_message", 16'(rec.last), 16'(out_last_of_message));
          check_field("bad_value", 16'(rec.bad), 16'(out_bad_value));
          if (rec.kind == KIND_STOP) begin
            message_count++;
          end
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    message_count = 0;
    msg_pos = 7'd0;
    running_sum = SUM_SEED;
  end

endmodule

// ===== test/code128_set_c_encoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// code128_set_c_encoder_unit_tb
// Drives symbol values into the set C encoder with random gaps and result
// back-pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module code128_set_c_encoder_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 86;
  localparam int CALM_FROM    = 70;
  localparam int PAUSE_AT     = 40;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 10;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [6:0]  in_symbol_value;
  logic        out_valid;
  logic        out_ready;
  logic [12:0] out_pattern;
  logic [3:0]  out_pattern_width;
  logic [1:0]  out_symbol_kind;
  logic        out_last_of_message;
  logic        out_bad_value;

  int fail_count;
  int pending_count;
  int message_count;
  int sent_count;
  int bad_sent;
  int stall_cycles;
  bit calm;

  code128_set_c_encoder_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_symbol_value     (in_symbol_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pattern         (out_pattern),
    .out_pattern_width   (out_pattern_width),
    .out_symbol_kind     (out_symbol_kind),
    .out_last_of_message (out_last_of_message),
    .out_bad_value       (out_bad_value)
  );

  code128_set_c_encoder_checker pattern_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_symbol_value     (in_symbol_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pattern         (out_pattern),
    .out_pattern_width   (out_pattern_width),
    .out_symbol_kind     (out_symbol_kind),
    .out_last_of_message (out_last_of_message),
    .out_bad_value       (out_bad_value),
    .fail_count          (fail_count),
    .pending_count       (pending_count),
    .message_count       (message_count)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side back-pressure: ready stretches and stall bursts.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      if (!calm) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
    end
  end

  // Offers one value, with an occasional idle burst before it, and holds it
  // until the transfer.
  task automatic send_symbol(input logic [6:0] value);
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_symbol_value <= value;
    if (value > 7'd106) begin
      bad_sent++;
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Drops valid and waits until every predicted symbol has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
  endtask

  // Random value: mostly digit pairs, some control codes, some out of table.
  function automatic logic [6:0] random_value();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      return 7'($urandom_range(0, 99));
    end else if (pick < 17) begin
      return 7'($urandom_range(100, 106));
    end else begin
      return 7'($urandom_range(107, 127));
    end
  endfunction

  // Directed messages: field extremes, patterns 7, 81 and 82, control codes
  // as data, values past the table, and an all-99 message.
  localparam logic [6:0] DIRECTED [24] = '{
    7'd0,   7'd127, 7'd7,   7'd81,  7'd82,  7'd99,  7'd100, 7'd101,
    7'd102, 7'd103, 7'd104, 7'd105, 7'd106, 7'd107, 7'd126, 7'd1,
    7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99,  7'd99
  };

  // Stimulus and verdict.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_symbol_value = 7'd0;
    calm = 1'b0;
    sent_count = 0;
    bad_sent = 0;
    stall_cycles = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_symbol(DIRECTED[i]);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PAUSE_AT) begin
        drain_results();
      end
      if (i == CALM_FROM) begin
        calm = 1'b1;
      end
      send_symbol(random_value());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Encoded %0d symbol values into %0d complete messages (%0d out of table),",
             sent_count, message_count, bad_sent);
    $display("with random input gaps, result stalls and a mid-run drain.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
